[hw/rtl/wah_bitmap_index_encoder_macros.svh]
// Assertion macros used by the bitmap encoder top level.
`ifndef WAH_BITMAP_INDEX_ENCODER_MACROS_SVH
`define WAH_BITMAP_INDEX_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
`define WBIE_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");
`define WBIE_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");
`else
`define WBIE_ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define WBIE_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[hw/rtl/wbie_pkg.sv]
// Types, constants and helpers shared by the bitmap encoder modules.
`default_nettype none

package wbie_pkg;

	localparam int CHUNK_BITS = 31;
	localparam int KEY_W      = 32;
	localparam int ROW_W      = 32;
	localparam int CHUNK_W    = 28;
	localparam int POS_W      = 5;
	localparam int CNT_W      = 29;
	localparam int WORD_W     = 32;

	// Reciprocal of CHUNK_BITS: chunk = (row_id * DIV_MAGIC) >> DIV_SHIFT, exact for 32-bit ids.
	localparam int DIV_SHIFT = 37;
	localparam int MAGIC_W   = 33;
	localparam logic [MAGIC_W-1:0] DIV_MAGIC =
		MAGIC_W'(((64'd1 << DIV_SHIFT) + CHUNK_BITS - 1) / CHUNK_BITS);
	localparam int PROD_W = ROW_W + MAGIC_W;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// One closed group, to be expanded into an optional fill word and a literal word.
	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic [CHUNK_W-1:0]    fill;
		logic [CHUNK_BITS-1:0] literal;
		logic                  last_of_key;
		logic                  run_last;
	} close_rec_t;

	// Up to two closed groups per input transaction, oldest in slot a.
	typedef struct packed {
		logic       valid_a;
		logic       valid_b;
		close_rec_t rec_a;
		close_rec_t rec_b;
	} push_t;

	typedef enum logic {
		PH_FILL,
		PH_LIT
	} phase_t;

	// Zero-fill length ahead of a group, saturating at zero for out-of-order chunks.
	function automatic logic [CHUNK_W-1:0] fill_count(
		input logic               first,
		input logic [CHUNK_W-1:0] chunk,
		input logic [CHUNK_W-1:0] prev
	);
		logic [CHUNK_W-1:0] res;
		if (first)
			res = chunk;
		else if (chunk > prev)
			res = chunk - prev - CHUNK_W'(1);
		else
			res = '0;
		return res;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/wbie_front.sv]
// Front end: accepts pairs, splits row ids into chunks and closes groups.
`default_nettype none

module wbie_front import wbie_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic [ROW_W-1:0] row_id,
	input  wire logic             end_of_data,
	input  wire logic             room,
	output push_t                 push
);

	logic [PROD_W-1:0] prod;
	logic              valid_s1;
	logic [KEY_W-1:0]  key_s1;
	logic [CHUNK_W-1:0] chunk_s1;
	logic [POS_W-1:0]  low_s1;
	logic              eod_s1;

	logic                  open_q;
	logic [KEY_W-1:0]      gkey_q;
	logic [CHUNK_W-1:0]    gchunk_q;
	logic [CHUNK_BITS-1:0] glit_q;
	logic [CHUNK_W-1:0]    prev_q;
	logic                  first_q;

	logic                  fire;
	logic                  same;
	logic                  close_a;
	logic                  key_change;
	logic [POS_W-1:0]      pos;
	logic [CHUNK_BITS-1:0] bit_hot;
	logic [CHUNK_BITS-1:0] new_lit;
	logic [KEY_W-1:0]      new_key;
	logic [CHUNK_W-1:0]    new_chunk;
	logic [CHUNK_W-1:0]    prev_a;
	logic                  first_a;

	assign prod = PROD_W'(row_id) * PROD_W'(DIV_MAGIC);

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_s1   <= key;
			chunk_s1 <= prod[DIV_SHIFT +: CHUNK_W];
			low_s1   <= row_id[POS_W-1:0];
			eod_s1   <= end_of_data;
		end
	end

	always_comb begin
		// remainder = id - 32q + q, so its low bits are id + q modulo 32
		pos        = low_s1 + chunk_s1[POS_W-1:0];
		bit_hot    = CHUNK_BITS'(1) << pos;
		key_change = key_s1 != gkey_q;
		same       = open_q && !key_change && (chunk_s1 == gchunk_q);
		close_a    = open_q && !same;
		new_key    = key_s1;
		new_chunk  = chunk_s1;
		new_lit    = same ? (glit_q | bit_hot) : bit_hot;
		prev_a     = close_a ? gchunk_q : prev_q;
		first_a    = close_a ? key_change : first_q;

		push.valid_a           = fire && close_a;
		push.rec_a.key         = gkey_q;
		push.rec_a.fill        = fill_count(first_q, gchunk_q, prev_q);
		push.rec_a.literal     = glit_q;
		push.rec_a.last_of_key = key_change;
		push.rec_a.run_last    = !eod_s1;

		push.valid_b           = fire && eod_s1;
		push.rec_b.key         = new_key;
		push.rec_b.fill        = fill_count(first_a, new_chunk, prev_a);
		push.rec_b.literal     = new_lit;
		push.rec_b.last_of_key = 1'b1;
		push.rec_b.run_last    = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			gkey_q   <= '0;
			gchunk_q <= '0;
			glit_q   <= '0;
			prev_q   <= '0;
			first_q  <= 1'b1;
		end else if (fire) begin
			if (eod_s1) begin
				open_q   <= 1'b0;
				gkey_q   <= '0;
				gchunk_q <= '0;
				glit_q   <= '0;
				prev_q   <= '0;
				first_q  <= 1'b1;
			end else begin
				open_q   <= 1'b1;
				gkey_q   <= new_key;
				gchunk_q <= new_chunk;
				glit_q   <= new_lit;
				prev_q   <= prev_a;
				first_q  <= first_a;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wbie_queue.sv]
// Short queue of closed groups between front and back; takes up to two per cycle.
`default_nettype none

module wbie_queue import wbie_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  push_t      push,
	output logic       room,
	output logic       head_valid,
	output close_rec_t head,
	input  wire logic  pop
);

	close_rec_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] n_push;
	logic              do_pop;
	close_rec_t        first_rec;

	assign n_push     = QCNT_W'(push.valid_a) + QCNT_W'(push.valid_b);
	assign do_pop     = pop && head_valid;
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];
	assign room       = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign first_rec  = push.valid_a ? push.rec_a : push.rec_b;

	always_ff @(posedge clk) begin
		if (n_push != '0)
			mem_q[wr_q] <= first_rec;
		if (push.valid_a && push.valid_b)
			mem_q[wr_q + QPTR_W'(1)] <= push.rec_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + n_push[QPTR_W-1:0];
			rd_q  <= rd_q + QPTR_W'(do_pop);
			cnt_q <= cnt_q + n_push - QCNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wbie_back.sv]
// Back end: expands closed groups into WAH words and counts words per key.
`default_nettype none

module wbie_back import wbie_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  close_rec_t             head,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [KEY_W-1:0]       key_out,
	output logic [WORD_W-1:0]      word,
	output logic                   end_of_key,
	output logic [CNT_W-1:0]       key_words,
	output logic                   run_last
);

	phase_t           phase_q;
	phase_t           phase_d;
	logic             out_free;
	logic             emit;
	logic             is_lit;
	logic [CNT_W-1:0] words_q;
	logic [CNT_W-1:0] words_inc;

	assign out_free  = !out_valid || out_ready;
	assign emit      = head_valid && out_free;
	assign words_inc = (words_q == COUNT_MAX) ? words_q : words_q + CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			phase_q <= PH_FILL;
		else
			phase_q <= phase_d;
	end

	always_comb begin
		phase_d = phase_q;
		is_lit  = 1'b1;
		pop     = 1'b0;
		unique case (phase_q)
			PH_FILL: begin
				if (head.fill != '0) begin
					is_lit = 1'b0;
					if (emit)
						phase_d = PH_LIT;
				end else begin
					pop = emit;
				end
			end
			PH_LIT: begin
				pop = emit;
				if (emit)
					phase_d = PH_FILL;
			end
			default: begin
				phase_d = PH_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			words_q   <= '0;
		end else begin
			if (out_free)
				out_valid <= head_valid;
			if (emit)
				words_q <= (is_lit && head.last_of_key) ? '0 : words_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			key_out    <= head.key;
			word       <= is_lit ? {1'b1, head.literal} : WORD_W'(head.fill);
			end_of_key <= is_lit && head.last_of_key;
			key_words  <= (is_lit && head.last_of_key) ? words_inc : '0;
			run_last   <= is_lit && head.run_last;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/wah_bitmap_index_encoder.sv]
// Path: a closed group goes from the front stage register through the queue into the output register.
// Throughput: a pair is taken every cycle while the group queue has room for two
// closed groups; the output port drains one word a cycle while m_tready is high, and
// a pair causes 0 to 4 output words.
// Reset: arst_n clears the open group, the queue and the output register at once.
`default_nettype none
`include "wah_bitmap_index_encoder_macros.svh"

module wah_bitmap_index_encoder import wbie_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input pairs
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // key [31:0], row_id [63:32]
	input  wire logic        s_tlast,  // end_of_data
	// output words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,  // key_out [31:0], word [63:32], key_words [92:64], zero pad
	output logic             m_tlast,  // end_of_key
	output logic [0:0]       m_tuser   // run_last
);

	// Group closes travel front -> queue -> back; each side stalls on its own.
	push_t            push;
	logic             room;
	logic             head_valid;
	close_rec_t       head;
	logic             pop;
	logic [KEY_W-1:0] key_out;
	logic [WORD_W-1:0] word;
	logic             end_of_key;
	logic [CNT_W-1:0] key_words;
	logic             run_last;

	// Front: reciprocal multiply for chunk, then compare against the open group.
	wbie_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.key         (s_tdata[31:0]),
		.row_id      (s_tdata[63:32]),
		.end_of_data (s_tlast),
		.room        (room),
		.push        (push)
	);

	// Queue: holds closed groups so a burst of closes does not stall intake.
	wbie_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Back: one word a cycle into the output register while m_tready allows, fill word first.
	wbie_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.key_out    (key_out),
		.word       (word),
		.end_of_key (end_of_key),
		.key_words  (key_words),
		.run_last   (run_last)
	);

	assign m_tdata = {3'b000, key_words, word, key_out};
	assign m_tlast = end_of_key;
	assign m_tuser = run_last;

	// A key's closing word always carries a nonzero word count.
	`WBIE_ASSERT_IMPLIES(a_count_on_last, clk, arst_n, m_tvalid && m_tlast, m_tdata[92:64] != 29'd0)
	// Fill words never close a key nor end a transaction's run.
	`WBIE_ASSERT_IMPLIES(a_fill_not_last, clk, arst_n, m_tvalid && !m_tdata[63], !m_tlast && !m_tuser[0])
	// Fill counts never reach bit 30.
	`WBIE_ASSERT_IMPLIES(a_fill_range, clk, arst_n, m_tvalid && !m_tdata[63], !m_tdata[62])

endmodule

`default_nettype wire
